@@ rtl/plpm_pkg.sv @@
`default_nettype none
package plpm_pkg;

	localparam int PIX_W      = 8;
	localparam int PT_W       = 16;
	localparam int REG_POINTS = 6;
	localparam int CNT_W      = 3;
	localparam int IDX_W      = 3;
	localparam int LUT_DEPTH  = 1 << PIX_W;
	localparam int NUM_W      = 2 * PIX_W + 1;
	localparam int BIT_W      = $clog2(PIX_W);

	localparam logic [PIX_W-1:0] START_POS   = 8'd0;
	localparam logic [PIX_W-1:0] START_LEVEL = 8'd1;
	localparam logic [PIX_W-1:0] END_POS     = 8'd255;
	localparam logic [PIX_W-1:0] END_LEVEL   = 8'd254;

	localparam logic [IDX_W-1:0] REG_COUNT      = 3'd0;
	localparam logic [IDX_W-1:0] REG_POINT0     = 3'd1;
	localparam logic [IDX_W-1:0] REG_POINT_LAST = 3'd6;

	typedef struct packed {
		logic [PIX_W-1:0] pos;
		logic [PIX_W-1:0] lev;
	} point_t;

	typedef struct packed {
		logic             en;
		logic [PIX_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} lut_wr_t;

	typedef enum logic [2:0] {
		BLD_IDLE,
		BLD_SELECT,
		BLD_MULT,
		BLD_DIV,
		BLD_WRITE
	} build_state_t;

endpackage
`default_nettype wire

@@ rtl/plpm_lut.sv @@
`default_nettype none
module plpm_lut import plpm_pkg::*; (
	input  logic             clk,
	input  lut_wr_t          wr,
	input  logic             rd_en,
	input  logic [PIX_W-1:0] rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [LUT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/plpm_build.sv @@
`default_nettype none
module plpm_build import plpm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CNT_W-1:0]            n_eff,
	input  point_t [REG_POINTS-1:0]     points,
	output logic                        busy,
	output lut_wr_t                     wr
);

	build_state_t state_q, state_d;

	logic [PIX_W-1:0] addr_q;

	logic [PIX_W-1:0] node_pos [REG_POINTS+2];
	logic [PIX_W-1:0] node_lev [REG_POINTS+2];

	logic [PIX_W-1:0] sel_b, sel_bl, sel_e, sel_el;

	logic [PIX_W-1:0] t_q, d_q, m_q, bl_q, el_q;
	logic             neg_q, zero_q;
	logic [NUM_W-1:0] num_q;
	logic [PIX_W-1:0] q_q;
	logic [BIT_W-1:0] bit_q;

	logic [2*PIX_W-1:0] prod;
	logic [NUM_W-1:0]   num_d;
	logic [NUM_W-1:0]   trial;
	logic [PIX_W-1:0]   result;

	// Breakpoints past the count in use collapse onto the end of the curve.
	always_comb begin
		node_pos[0] = START_POS;
		node_lev[0] = START_LEVEL;
		for (int j = 1; j <= REG_POINTS; j++) begin
			if (CNT_W'(j) <= n_eff) begin
				node_pos[j] = points[j-1].pos;
				node_lev[j] = points[j-1].lev;
			end else begin
				node_pos[j] = END_POS;
				node_lev[j] = END_LEVEL;
			end
		end
		node_pos[REG_POINTS+1] = END_POS;
		node_lev[REG_POINTS+1] = END_LEVEL;
	end

	// The last segment in chain order that holds the address wins.
	always_comb begin
		sel_b  = START_POS;
		sel_bl = START_LEVEL;
		sel_e  = END_POS;
		sel_el = END_LEVEL;
		for (int k = 0; k <= REG_POINTS; k++) begin
			if (CNT_W'(k) <= n_eff && node_pos[k] <= addr_q && addr_q <= node_pos[k+1]) begin
				sel_b  = node_pos[k];
				sel_bl = node_lev[k];
				sel_e  = node_pos[k+1];
				sel_el = node_lev[k+1];
			end
		end
	end

	assign prod   = t_q * m_q;
	assign num_d  = {prod, 1'b0} + NUM_W'(d_q) - NUM_W'(neg_q);
	assign trial  = NUM_W'({d_q, 1'b0}) << bit_q;
	assign result = zero_q ? el_q : (neg_q ? bl_q - q_q : bl_q + q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BLD_SELECT;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				addr_q <= '0;
			end else if (state_q == BLD_WRITE) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BLD_SELECT: begin
				t_q    <= addr_q - sel_b;
				d_q    <= sel_e - sel_b;
				zero_q <= (sel_e == sel_b);
				neg_q  <= (sel_el < sel_bl);
				m_q    <= (sel_el < sel_bl) ? sel_bl - sel_el : sel_el - sel_bl;
				bl_q   <= sel_bl;
				el_q   <= sel_el;
			end
			BLD_MULT: begin
				num_q <= num_d;
				q_q   <= '0;
				bit_q <= BIT_W'(PIX_W - 1);
			end
			BLD_DIV: begin
				if (num_q >= trial) begin
					num_q        <= num_q - trial;
					q_q[bit_q]   <= 1'b1;
				end
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != BLD_IDLE);
		wr.en   = 1'b0;
		wr.addr = addr_q;
		wr.data = result;
		case (state_q)
			BLD_IDLE:   state_d = BLD_IDLE;
			BLD_SELECT: state_d = BLD_MULT;
			BLD_MULT:   state_d = zero_q ? BLD_WRITE : BLD_DIV;
			BLD_DIV:    state_d = (bit_q == '0) ? BLD_WRITE : BLD_DIV;
			BLD_WRITE: begin
				wr.en   = 1'b1;
				state_d = (addr_q == END_POS) ? BLD_IDLE : BLD_SELECT;
			end
			default:    state_d = BLD_IDLE;
		endcase
		if (start) begin
			state_d = BLD_SELECT;
		end
	end

endmodule
`default_nettype wire

@@ rtl/piecewise_linear_pixel_map_top.sv @@
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata[7:0] = pixel_in
// m_*       out        m_tvalid / m_tready  m_tdata[7:0] = pixel_out
// cfg_*     in         cfg_we               cfg_addr = register, cfg_wdata = value
//
// Each pixel is looked up in a 256-entry curve table; one pixel per cycle is accepted while
// s_tready is high, and its result goes through the registered table read and the output queue.
// The table is rebuilt after reset and after every configuration write, entry by entry through
// select, multiply, divide (one divide bit per cycle) and write steps, the divide skipped for an
// entry on a zero-width segment; s_tready stays low during the rebuild.
// A four-entry output queue lets input continue while m_tready is low until it fills.
`default_nettype none
module piecewise_linear_pixel_map_top import plpm_pkg::*; #(
	parameter int MAX_POINTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,    // [7:0] pixel_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,    // [7:0] pixel_out
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_addr,
	input  logic [PT_W-1:0]  cfg_wdata
);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	logic [CNT_W-1:0]        point_count_q;
	point_t [REG_POINTS-1:0] points_q;
	logic [CNT_W-1:0]        n_eff;
	logic [IDX_W-1:0]        pt_idx;

	logic             build_busy;
	lut_wr_t          lut_wr;
	logic             in_acc;
	logic [PIX_W-1:0] lut_rdata;
	logic             valid_s1;

	logic [PIX_W-1:0]   fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               push, pop;

	assign pt_idx = cfg_addr - REG_POINT0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			points_q      <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == REG_COUNT) begin
				point_count_q <= cfg_wdata[CNT_W-1:0];
			end else if (cfg_addr >= REG_POINT0 && cfg_addr <= REG_POINT_LAST) begin
				points_q[pt_idx] <= cfg_wdata;
			end
		end
	end

	assign n_eff = (point_count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count_q;

	plpm_build u_build (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.n_eff  (n_eff),
		.points (points_q),
		.busy   (build_busy),
		.wr     (lut_wr)
	);

	plpm_lut u_lut (
		.clk     (clk),
		.wr      (lut_wr),
		.rd_en   (in_acc),
		.rd_addr (s_tdata),
		.rd_data (lut_rdata)
	);

	// Space is reserved for the lookup still in flight.
	assign s_tready = !build_busy &&
		((cnt_q + FIFO_CW'(valid_s1)) < FIFO_CW'(FIFO_DEPTH));
	assign in_acc   = s_tvalid && s_tready;
	assign push     = valid_s1;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= in_acc;
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= lut_rdata;
		end
	end

`ifndef SYNTHESIS
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> build_busy)
		else $error("Configuration write did not start a table rebuild.");

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == FIFO_CW'(FIFO_DEPTH)) |-> !valid_s1)
		else $error("Lookup result arrived with the output queue full.");

	a_no_lookup_during_build: assert property (@(posedge clk) disable iff (!arst_n)
		lut_wr.en |-> !valid_s1)
		else $error("Table write overlapped a pixel lookup.");
`endif

endmodule
`default_nettype wire

@@ tb/piecewise_linear_pixel_map_top_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module piecewise_linear_pixel_map_top_tb import plpm_pkg::*; ();

	localparam int CURVE_MAX_POINTS = 6;
	localparam int PIXEL_BUDGET = 1950;
	localparam int STALL_LIMIT = 100000;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'(REG_POINT_LAST + 1);

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_TOGGLE
	} ready_mode_t;

	typedef enum int {
		CURVE_SORTED,
		CURVE_SHUFFLED,
		CURVE_CLUSTERED,
		CURVE_STEEP
	} curve_style_t;

	class pixel_map_scoreboard;
		logic [CNT_W-1:0] point_count;
		point_t           pts[REG_POINTS];
		logic [PIX_W-1:0] pixels_due[$];
		logic [PIX_W-1:0] levels_due[$];
		int               errors;

		function new();
			point_count = '0;
			foreach (pts[k]) pts[k] = '0;
			errors = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [PT_W-1:0] value);
			if (idx == REG_COUNT) begin
				point_count = value[CNT_W-1:0];
			end else if (idx >= REG_POINT0 && idx <= REG_POINT_LAST) begin
				pts[idx - REG_POINT0] = value;
			end
		endfunction

		function int floor_div(int num, int den);
			if (num >= 0) return num / den;
			return -((-num + den - 1) / den);
		endfunction

		function logic [PIX_W-1:0] map_level(logic [PIX_W-1:0] pixel);
			int v, b, bl, e, el, n, d, num, level;
			v = pixel;
			b = START_POS;
			bl = START_LEVEL;
			level = 0;
			n = (point_count > CURVE_MAX_POINTS) ? CURVE_MAX_POINTS : point_count;
			for (int k = 0; k <= n; k++) begin
				if (k < n) begin
					e = pts[k].pos;
					el = pts[k].lev;
				end else begin
					e = END_POS;
					el = END_LEVEL;
				end
				if (b <= e && v >= b && v <= e) begin
					if (e == b) begin
						level = el;
					end else begin
						d = e - b;
						num = 2 * (v - b) * (el - bl) + d;
						level = bl + floor_div(num, 2 * d);
					end
				end
				b = e;
				bl = el;
			end
			return level[PIX_W-1:0];
		endfunction

		task report(string line);
			errors++;
			$display("%0t ns: %s", $time, line);
		endtask

		function int pending();
			return levels_due.size();
		endfunction

		function void note_pixel(logic [PIX_W-1:0] pixel);
			pixels_due = {pixels_due, pixel};
			levels_due = {levels_due, map_level(pixel)};
		endfunction

		task check_level(logic [PIX_W-1:0] got);
			logic [PIX_W-1:0] pixel, want;
			if (levels_due.size() == 0) begin
				report($sformatf("level %0d arrived with no pixel outstanding", got));
			end else begin
				pixel = pixels_due.pop_front();
				want = levels_due.pop_front();
				if (got !== want)
					report($sformatf("pixel %0d: pixel_out %0d, expected %0d",
						pixel, got, want));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_addr;
	logic [PT_W-1:0]  cfg_wdata;

	pixel_map_scoreboard sb;
	point_t              curve_pts[REG_POINTS];
	logic [PIX_W-1:0]    pixel_plan[$];
	int                  quiet_cycles = 0;

	piecewise_linear_pixel_map_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
			if (m_tvalid && m_tready) sb.check_level(m_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("piecewise_linear_pixel_map_top: mismatch");
			$finish;
		end
	end

	initial begin
		ready_mode_t mode;
		int span;
		m_tready = 1'b0;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
				READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:      m_tready <= ~m_tready;
				endcase
			end
		end
	end

	task automatic wait_drain();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		sb.set_register(idx, value);
		@(negedge clk);
	endtask

	task automatic load_curve(input logic [PT_W-1:0] count_word, input bit with_unused);
		wait_drain();
		write_reg(REG_COUNT, count_word);
		for (int k = 0; k < REG_POINTS; k++)
			write_reg(3'(REG_POINT0 + k), curve_pts[k]);
		if (with_unused) write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_curve();
		curve_style_t     style;
		point_t           tmp;
		logic [PT_W-1:0]  count_word;
		style = curve_style_t'($urandom_range(0, 3));
		for (int k = 0; k < REG_POINTS; k++) begin
			if (style == CURVE_CLUSTERED)
				curve_pts[k].pos = 8'($urandom_range(0, 6) * 40);
			else
				curve_pts[k].pos = 8'($urandom_range(0, 255));
			if (style == CURVE_STEEP)
				curve_pts[k].lev = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			else
				curve_pts[k].lev = 8'($urandom_range(0, 255));
		end
		if (style != CURVE_SHUFFLED) begin
			for (int i = 1; i < REG_POINTS; i++) begin
				for (int j = i; j > 0 && curve_pts[j-1].pos > curve_pts[j].pos; j--) begin
					tmp = curve_pts[j];
					curve_pts[j] = curve_pts[j-1];
					curve_pts[j-1] = tmp;
				end
			end
		end
		count_word = 16'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0) count_word[PT_W-1:CNT_W] = 13'($urandom);
		load_curve(count_word, $urandom_range(0, 4) == 0);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		int near;
		if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 255));
		near = int'(sb.pts[$urandom_range(0, REG_POINTS - 1)].pos)
			+ int'($urandom_range(0, 2)) - 1;
		return 8'(near);
	endfunction

	task automatic send_plan();
		int burst, gap;
		while (pixel_plan.size() != 0) begin
			burst = $urandom_range(1, 40);
			while (burst != 0 && pixel_plan.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_plan.pop_front();
				do @(posedge clk); while (!s_tready);
				@(negedge clk);
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0 && pixel_plan.size() != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (s_tvalid) s_tvalid <= 1'b0;
	endtask

	task automatic random_block(input int n);
		repeat (n / 2) pixel_plan = {pixel_plan, pick_pixel()};
		send_plan();
		wait_drain();
		repeat (n - n / 2) pixel_plan = {pixel_plan, pick_pixel()};
		send_plan();
	endtask

	initial begin
		int sent, n;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		pixel_plan = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'h55, 8'hAA};
		send_plan();

		// A count above the maximum, a zero-width step at 40, falling levels and a
		// final breakpoint sitting on the end position.
		curve_pts = '{16'h0000, 16'h28FF, 16'h280A, 16'h80C8, 16'hC014, 16'hFFFF};
		load_curve(16'd7, 1'b0);
		pixel_plan = '{8'd0, 8'd40, 8'd39, 8'd41, 8'd128, 8'd192, 8'd200, 8'd255,
			8'd100, 8'd64};
		send_plan();

		// Out-of-order positions leave some segments empty.
		curve_pts = '{16'hC810, 16'h32F0, 16'h9600, 16'h1480, 16'hFF00, 16'h00FF};
		load_curve(16'd5, 1'b1);
		pixel_plan = '{8'd0, 8'd20, 8'd50, 8'd150, 8'd200, 8'd255, 8'd128};
		send_plan();
		sent = 25;

		foreach (curve_pts[k]) curve_pts[k] = '1;
		load_curve(16'd6, 1'b0);
		random_block(150);
		foreach (curve_pts[k]) curve_pts[k] = '0;
		load_curve(16'hFFFF, 1'b1);
		random_block(150);
		sent += 300;

		while (sent < PIXEL_BUDGET) begin
			random_curve();
			n = $urandom_range(120, 260);
			random_block(n);
			sent += n;
		end

		wait_drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("piecewise_linear_pixel_map_top: match");
		else
			$display("piecewise_linear_pixel_map_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
